/* src/atd_pkg.sv */
// ----------------------------------------------------------------------------
// atd_pkg: shared types and constants
// Widths, payload words, register codes and the start-sequence state type for
// the affine transposition decryption block.
// ----------------------------------------------------------------------------
`default_nettype none

package atd_pkg;

	localparam int MAX_LEN    = 4096;
	localparam int MAX_PERIOD = 64;

	// config register widths
	localparam int PERIOD_W = 7;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;

	// derived widths
	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int IDX_W  = $clog2(MAX_LEN + 2 * MAX_PERIOD);
	localparam int RES_W  = $clog2(MAX_PERIOD);
	localparam int EFF_W  = RES_W + 1;
	localparam int DVD_W  = (IDX_W > CFG_W) ? IDX_W : CFG_W;
	localparam int CNT_W  = $clog2(DVD_W + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EMIT = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       residue_exhausted;
	} rsp_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [EFF_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] rem;
	} mod_rsp_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_MOD_LEN,
		ST_MOD_MULT,
		ST_MOD_OFS
	} state_t;

endpackage

`default_nettype wire

/* src/atd_ram.sv */
// ----------------------------------------------------------------------------
// atd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
`default_nettype none

module atd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/atd_mod.sv */
// ----------------------------------------------------------------------------
// atd_mod: bit-serial remainder unit
// Restoring remainder of a DVD_W-bit value by the effective period, one
// dividend bit per cycle; done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module atd_mod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire atd_pkg::mod_req_t req,
	output      atd_pkg::mod_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [atd_pkg::CNT_W-1:0]   cnt_q;
	logic [atd_pkg::DVD_W-1:0]   dvd_q;
	logic [atd_pkg::EFF_W-1:0]   dsr_q;
	logic [atd_pkg::RES_W-1:0]   rem_q;
	logic [atd_pkg::EFF_W-1:0]   trial;
	logic [atd_pkg::EFF_W-1:0]   diff;

	assign trial = {rem_q, dvd_q[atd_pkg::DVD_W-1]};
	assign diff  = trial - dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= atd_pkg::CNT_W'(atd_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == atd_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[atd_pkg::DVD_W-2:0], 1'b0};
			// remainder stays below the divisor, so it fits RES_W bits
			if (trial >= dsr_q) begin
				rem_q <= diff[atd_pkg::RES_W-1:0];
			end else begin
				rem_q <= trial[atd_pkg::RES_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

/* src/affine_transposition_decrypt.sv */
// ----------------------------------------------------------------------------
// affine_transposition_decrypt: load-then-emit transposition decryption
// Load words fill the message memory; emit words return the padded message
// in affine residue order, using a per-residue next-index table.
// ----------------------------------------------------------------------------
// Pipeline: an answered emit word passes stage 1 (table read) and stage 2
//   (message read) to rsp; a load is written to memory at acceptance and gives no word.
// Throughput: one word per cycle while emitting and rsp is not stalled. The
//   first emit after a load phase is held while the serial remainder unit
//   reduces length, mult and offset by the period.
// Reset: control, config (to defaults) and table valid bits clear at once; message memory
//   is not cleared (only written entries are ever read).
`default_nettype none

module affine_transposition_decrypt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request channel
	input  wire logic                            req_valid,
	output      logic                            req_stall,
	input  wire atd_pkg::req_t                   req,
	// response channel
	output      logic                            rsp_valid,
	input  wire logic                            rsp_stall,
	output      atd_pkg::rsp_t                   rsp,
	// config write port
	input  wire logic                            cfg_we,
	input  wire logic [atd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [atd_pkg::CFG_W-1:0]       cfg_data
);

	// ---------------- config registers ----------------
	logic [atd_pkg::PERIOD_W-1:0] period_cfg_q;
	logic [atd_pkg::CFG_W-1:0]    mult_cfg_q;
	logic [atd_pkg::CFG_W-1:0]    offset_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cfg_q <= atd_pkg::PERIOD_W'(2);
			mult_cfg_q   <= atd_pkg::CFG_W'(1);
			offset_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				atd_pkg::REG_PERIOD: period_cfg_q <= cfg_data[atd_pkg::PERIOD_W-1:0];
				atd_pkg::REG_MULT:   mult_cfg_q   <= cfg_data;
				atd_pkg::REG_OFFSET: offset_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp period into 2..MAX_PERIOD
	logic [atd_pkg::EFF_W-1:0] eff_period;

	always_comb begin
		if (period_cfg_q < atd_pkg::PERIOD_W'(2)) begin
			eff_period = atd_pkg::EFF_W'(2);
		end else if (int'(period_cfg_q) > atd_pkg::MAX_PERIOD) begin
			eff_period = atd_pkg::EFF_W'(atd_pkg::MAX_PERIOD);
		end else begin
			eff_period = atd_pkg::EFF_W'(period_cfg_q);
		end
	end

	// ---------------- control state ----------------
	atd_pkg::state_t              state_q, state_d;
	logic                         emitting_q;
	logic [atd_pkg::IDX_W-1:0]    len_q;
	logic [atd_pkg::IDX_W-1:0]    padded_q;
	logic [atd_pkg::IDX_W-1:0]    pos_q;
	logic [atd_pkg::RES_W-1:0]    res_q;
	logic [atd_pkg::RES_W-1:0]    step_q;
	logic [atd_pkg::EFF_W-1:0]    period_q;
	logic [atd_pkg::MAX_PERIOD-1:0] tvalid_q;

	// stage 1: table read done, index resolved
	logic                         v_s1;
	logic [atd_pkg::RES_W-1:0]    res_s1;
	logic                         last_s1;
	logic [atd_pkg::IDX_W-1:0]    len_s1;
	logic                         tv_s1;
	logic                         fwd_s1;
	logic [atd_pkg::IDX_W-1:0]    fwdval_s1;

	// stage 2: message read done, word offered
	logic                         v_s2;
	logic                         last_s2;
	logic                         exh_s2;
	logic                         use_s2;

	atd_pkg::mod_req_t            mod_req;
	atd_pkg::mod_rsp_t            mod_rsp;

	logic [atd_pkg::IDX_W-1:0]    tab_rdata;
	logic [7:0]                   msg_rdata;

	// ---------------- handshake ----------------
	logic take, load_go, emit_go, need_start;
	logic adv2, s1_adv, can_take, s1_wr;

	assign adv2     = !v_s2 || !rsp_stall;
	assign s1_adv   = v_s1 && adv2;
	assign can_take = !v_s1 || adv2;

	// an emit request in the load phase is held until the start sequence ends
	assign req_stall = (state_q != atd_pkg::ST_RUN) || !can_take ||
		(req.kind == atd_pkg::KIND_EMIT && !emitting_q);

	assign take    = req_valid && !req_stall;
	assign load_go = take && (req.kind == atd_pkg::KIND_LOAD);
	assign emit_go = take && (req.kind == atd_pkg::KIND_EMIT) && (pos_q < padded_q);

	// s1 must drain first: it still uses the old table and padded length
	assign need_start = (state_q == atd_pkg::ST_RUN) && req_valid &&
		(req.kind == atd_pkg::KIND_EMIT) && !emitting_q && !v_s1;

	// ---------------- start sequence FSM ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			atd_pkg::ST_RUN:      if (need_start) state_d = atd_pkg::ST_MOD_LEN;
			atd_pkg::ST_MOD_LEN:  if (mod_rsp.done) state_d = atd_pkg::ST_MOD_MULT;
			atd_pkg::ST_MOD_MULT: if (mod_rsp.done) state_d = atd_pkg::ST_MOD_OFS;
			atd_pkg::ST_MOD_OFS:  if (mod_rsp.done) state_d = atd_pkg::ST_RUN;
			default:              state_d = atd_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		mod_req.start    = 1'b0;
		mod_req.dividend = atd_pkg::DVD_W'(len_q);
		mod_req.divisor  = period_q;
		unique case (state_q)
			atd_pkg::ST_RUN: begin
				mod_req.start   = need_start;
				mod_req.divisor = eff_period;
			end
			atd_pkg::ST_MOD_LEN: begin
				mod_req.start    = mod_rsp.done;
				mod_req.dividend = atd_pkg::DVD_W'(mult_cfg_q);
			end
			atd_pkg::ST_MOD_MULT: begin
				mod_req.start    = mod_rsp.done;
				mod_req.dividend = atd_pkg::DVD_W'(offset_cfg_q);
			end
			atd_pkg::ST_MOD_OFS: ;
			default: ;
		endcase
	end

	atd_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// ---------------- emit datapath ----------------
	logic [atd_pkg::RES_W:0]   res_sum;
	logic [atd_pkg::RES_W-1:0] res_next;
	logic [atd_pkg::IDX_W-1:0] idx_s1;
	logic [atd_pkg::IDX_W-1:0] nidx_s1;
	logic                      exh_s1;
	logic                      use_s1;
	logic [atd_pkg::IDX_W-1:0] pad_add;

	// both terms are below the period, so one subtract reduces the sum
	assign res_sum  = {1'b0, res_q} + {1'b0, step_q};
	assign res_next = (res_sum >= period_q) ? atd_pkg::RES_W'(res_sum - period_q)
		: res_sum[atd_pkg::RES_W-1:0];

	// forwarded value wins over a table read that missed the previous write;
	// an entry never written this pass reads as its own residue
	always_comb begin
		if (fwd_s1) begin
			idx_s1 = fwdval_s1;
		end else if (tv_s1) begin
			idx_s1 = tab_rdata;
		end else begin
			idx_s1 = atd_pkg::IDX_W'(res_s1);
		end
	end

	assign nidx_s1 = idx_s1 + atd_pkg::IDX_W'(period_q);
	assign exh_s1  = !(idx_s1 < padded_q);
	assign use_s1  = !exh_s1 && (idx_s1 < len_s1);
	assign s1_wr   = s1_adv && !exh_s1;

	// padding up to a multiple of the period
	assign pad_add = (mod_rsp.rem == '0) ? '0
		: atd_pkg::IDX_W'(period_q) - atd_pkg::IDX_W'(mod_rsp.rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= atd_pkg::ST_RUN;
			emitting_q <= 1'b0;
			len_q      <= '0;
			padded_q   <= '0;
			pos_q      <= '0;
			res_q      <= '0;
			step_q     <= '0;
			period_q   <= atd_pkg::EFF_W'(2);
			tvalid_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			state_q <= state_d;

			// loads; a load while emitting opens a new message
			if (load_go) begin
				if (emitting_q) begin
					emitting_q <= 1'b0;
					len_q      <= atd_pkg::IDX_W'(1);
				end else if (len_q < atd_pkg::IDX_W'(atd_pkg::MAX_LEN)) begin
					len_q <= len_q + 1'b1;
				end
			end

			// start sequence
			if (need_start) begin
				period_q <= eff_period;
			end
			if (mod_rsp.done) begin
				unique case (state_q)
					atd_pkg::ST_MOD_LEN:  padded_q <= len_q + pad_add;
					atd_pkg::ST_MOD_MULT: step_q   <= mod_rsp.rem;
					atd_pkg::ST_MOD_OFS: begin
						res_q      <= mod_rsp.rem;
						pos_q      <= '0;
						emitting_q <= 1'b1;
						tvalid_q   <= '0;
					end
					default: ;
				endcase
			end

			if (emit_go) begin
				pos_q <= pos_q + 1'b1;
				res_q <= res_next;
			end

			if (s1_wr) begin
				tvalid_q[res_s1] <= 1'b1;
			end

			// stage valids
			if (emit_go) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end

			if (s1_adv) begin
				v_s2 <= 1'b1;
			end else if (v_s2 && !rsp_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_s1    <= res_q;
			last_s1   <= (pos_q + 1'b1) == padded_q;
			len_s1    <= len_q;
			tv_s1     <= tvalid_q[res_q];
			fwd_s1    <= s1_wr && (res_s1 == res_q);
			fwdval_s1 <= nidx_s1;
		end
		if (s1_adv) begin
			last_s2 <= last_s1;
			exh_s2  <= exh_s1;
			use_s2  <= use_s1;
		end
	end

	// ---------------- memories ----------------
	logic [atd_pkg::ADDR_W-1:0] msg_waddr;

	assign msg_waddr = emitting_q ? '0 : len_q[atd_pkg::ADDR_W-1:0];

	atd_ram #(
		.WIDTH (8),
		.DEPTH (atd_pkg::MAX_LEN)
	) u_msg_ram (
		.clk   (clk),
		.we    (load_go && (emitting_q || len_q < atd_pkg::IDX_W'(atd_pkg::MAX_LEN))),
		.waddr (msg_waddr),
		.wdata (req.data_byte),
		.re    (s1_adv && use_s1),
		.raddr (idx_s1[atd_pkg::ADDR_W-1:0]),
		.rdata (msg_rdata)
	);

	atd_ram #(
		.WIDTH (atd_pkg::IDX_W),
		.DEPTH (atd_pkg::MAX_PERIOD)
	) u_tab_ram (
		.clk   (clk),
		.we    (s1_wr),
		.waddr (res_s1),
		.wdata (nidx_s1),
		.re    (emit_go),
		.raddr (res_q),
		.rdata (tab_rdata)
	);

	// ---------------- response ----------------
	assign rsp_valid             = v_s2;
	assign rsp.out_byte          = use_s2 ? msg_rdata : 8'd0;
	assign rsp.is_last           = last_s2;
	assign rsp.residue_exhausted = exh_s2;

endmodule

`default_nettype wire
